[rtl/cis_pkg.sv]
// shared types and constants of the camera interval shot sequencer
package cis_pkg;

	localparam int TICK_COUNT_WIDTH = 12;
	localparam int INTERVAL_W = 12;
	localparam int PULSES_W = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 12;

	typedef enum logic [4:0] {
		PH_IDLE        = 5'd0,
		PH_KEY_SETTLE  = 5'd1,
		PH_FLASH_HI    = 5'd2,
		PH_FLASH_LO    = 5'd3,
		PH_STARTUP     = 5'd4,
		PH_PWR_PULSE   = 5'd5,
		PH_OFF1        = 5'd6,
		PH_ON1         = 5'd7,
		PH_SHUT_SETTLE = 5'd8,
		PH_SHUT_PULSE  = 5'd9,
		PH_OFF2        = 5'd10,
		PH_ON2         = 5'd11,
		PH_OFF_SETTLE  = 5'd12,
		PH_PWR_HOLD    = 5'd13,
		PH_INTERVAL    = 5'd14,
		PH_EXIT_HI     = 5'd15,
		PH_EXIT_LO     = 5'd16
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INTERVAL      = 3'd0,
		REG_POWER_PULSE   = 3'd1,
		REG_SHUTTER_PULSE = 3'd2,
		REG_SETTLE        = 3'd3,
		REG_STARTUP       = 3'd4,
		REG_FLASH_HALF    = 3'd5,
		REG_FLASH_COUNT   = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [11:0] interval_ticks;
		logic [7:0]  power_pulse_ticks;
		logic [7:0]  shutter_pulse_ticks;
		logic [7:0]  settle_ticks;
		logic [11:0] startup_ticks;
		logic [7:0]  flash_half_ticks;
		logic [3:0]  flash_count;
	} cfg_t;

	typedef struct packed {
		logic       power_drive;
		logic       shutter_drive;
		logic [4:0] phase_code;
	} res_t;

endpackage

[rtl/cis_cfg_regs.sv]
// configuration register file of the shot sequencer
module cis_cfg_regs
	import cis_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.interval_ticks      <= 12'd600;
			cfg_q.power_pulse_ticks   <= 8'd26;
			cfg_q.shutter_pulse_ticks <= 8'd1;
			cfg_q.settle_ticks        <= 8'd2;
			cfg_q.startup_ticks       <= 12'd60;
			cfg_q.flash_half_ticks    <= 8'd2;
			cfg_q.flash_count         <= 4'd5;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_INTERVAL:      cfg_q.interval_ticks      <= cfg_data[11:0];
				REG_POWER_PULSE:   cfg_q.power_pulse_ticks   <= cfg_data[7:0];
				REG_SHUTTER_PULSE: cfg_q.shutter_pulse_ticks <= cfg_data[7:0];
				REG_SETTLE:        cfg_q.settle_ticks        <= cfg_data[7:0];
				REG_STARTUP:       cfg_q.startup_ticks       <= cfg_data[11:0];
				REG_FLASH_HALF:    cfg_q.flash_half_ticks    <= cfg_data[7:0];
				REG_FLASH_COUNT:   cfg_q.flash_count         <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

endmodule

[rtl/cis_phase_core.sv]
// phase state machine, delay, interval and pulse counters, one update per tick
module cis_phase_core
	import cis_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic step_en,
	input  logic button,
	input  logic led_off,
	input  cfg_t cfg,
	output res_t res
);

	phase_t                      phase_q, phase_d;
	logic [TICK_COUNT_WIDTH-1:0] delay_q, delay_d, dly_dec;
	logic [INTERVAL_W-1:0]       interval_q, interval_d;
	logic [PULSES_W-1:0]         pulses_q, pulses_d, pls_dec;
	logic                        dly_done;

	// counters that stop at zero
	assign dly_dec  = (delay_q != '0) ? delay_q - 1'b1 : '0;
	assign dly_done = (dly_dec == '0);
	assign pls_dec  = (pulses_q != '0) ? pulses_q - 1'b1 : '0;

	// next state
	always_comb begin
		phase_d    = phase_q;
		delay_d    = delay_q;
		pulses_d   = pulses_q;
		interval_d = (interval_q != '0) ? interval_q - 1'b1 : '0;
		case (phase_q)
			PH_IDLE: begin
				if (button) begin
					phase_d = PH_KEY_SETTLE;
					delay_d = TICK_COUNT_WIDTH'(cfg.settle_ticks);
				end
			end
			PH_KEY_SETTLE: begin
				delay_d = dly_dec;
				if (dly_done) begin
					pulses_d = cfg.flash_count;
					phase_d  = PH_FLASH_HI;
					delay_d  = TICK_COUNT_WIDTH'(cfg.flash_half_ticks);
				end
			end
			PH_FLASH_HI, PH_EXIT_HI: begin
				delay_d = dly_dec;
				if (dly_done) begin
					phase_d = (phase_q == PH_FLASH_HI) ? PH_FLASH_LO : PH_EXIT_LO;
					delay_d = TICK_COUNT_WIDTH'(cfg.flash_half_ticks);
				end
			end
			PH_FLASH_LO, PH_EXIT_LO: begin
				delay_d = dly_dec;
				if (dly_done) begin
					pulses_d = pls_dec;
					if (pls_dec != '0) begin
						phase_d = (phase_q == PH_FLASH_LO) ? PH_FLASH_HI : PH_EXIT_HI;
						delay_d = TICK_COUNT_WIDTH'(cfg.flash_half_ticks);
					end else if (phase_q == PH_FLASH_LO) begin
						phase_d = PH_STARTUP;
						delay_d = TICK_COUNT_WIDTH'(cfg.startup_ticks);
					end else begin
						phase_d = PH_IDLE;
					end
				end
			end
			PH_STARTUP: begin
				delay_d = dly_dec;
				if (dly_done) begin
					interval_d = cfg.interval_ticks;
					phase_d    = PH_PWR_PULSE;
					delay_d    = TICK_COUNT_WIDTH'(cfg.power_pulse_ticks);
				end
			end
			PH_PWR_PULSE: begin
				delay_d = dly_dec;
				if (dly_done)
					phase_d = PH_OFF1;
			end
			PH_OFF1: begin
				if (led_off)
					phase_d = PH_ON1;
			end
			PH_ON1: begin
				if (!led_off) begin
					phase_d = PH_SHUT_SETTLE;
					delay_d = TICK_COUNT_WIDTH'(cfg.settle_ticks);
				end
			end
			PH_SHUT_SETTLE: begin
				delay_d = dly_dec;
				if (dly_done) begin
					phase_d = PH_SHUT_PULSE;
					delay_d = TICK_COUNT_WIDTH'(cfg.shutter_pulse_ticks);
				end
			end
			PH_SHUT_PULSE: begin
				delay_d = dly_dec;
				if (dly_done)
					phase_d = PH_OFF2;
			end
			PH_OFF2: begin
				if (led_off)
					phase_d = PH_ON2;
			end
			PH_ON2: begin
				if (!led_off) begin
					phase_d = PH_OFF_SETTLE;
					delay_d = TICK_COUNT_WIDTH'(cfg.settle_ticks);
				end
			end
			PH_OFF_SETTLE: begin
				delay_d = dly_dec;
				if (dly_done)
					phase_d = PH_PWR_HOLD;
			end
			PH_PWR_HOLD: begin
				if (led_off)
					phase_d = PH_INTERVAL;
			end
			PH_INTERVAL: begin
				if (interval_d == '0) begin
					interval_d = cfg.interval_ticks;
					phase_d    = PH_PWR_PULSE;
					delay_d    = TICK_COUNT_WIDTH'(cfg.power_pulse_ticks);
				end else if (button) begin
					pulses_d = cfg.flash_count;
					phase_d  = PH_EXIT_HI;
					delay_d  = TICK_COUNT_WIDTH'(cfg.flash_half_ticks);
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	// line drives for the current phase
	always_comb begin
		res.power_drive   = 1'b0;
		res.shutter_drive = 1'b0;
		res.phase_code    = phase_q;
		case (phase_q)
			PH_FLASH_HI, PH_PWR_PULSE, PH_PWR_HOLD, PH_EXIT_HI: res.power_drive = 1'b1;
			PH_SHUT_PULSE: res.shutter_drive = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			delay_q    <= '0;
			interval_q <= '0;
			pulses_q   <= '0;
		end else if (step_en) begin
			phase_q    <= phase_d;
			delay_q    <= delay_d;
			interval_q <= interval_d;
			pulses_q   <= pulses_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && phase_q == PH_IDLE && !button |=> phase_q == PH_IDLE)
		else $error("idle left without a button press");

	a_no_step_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!step_en |=> $stable(phase_q) && $stable(delay_q) && $stable(interval_q))
		else $error("state moved without a tick");

	a_interval_counts: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && interval_q != '0 && phase_q != PH_STARTUP && phase_q != PH_INTERVAL
		|=> interval_q == $past(interval_q) - 1'b1)
		else $error("interval counter did not count down");

	a_led_wait: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && phase_q == PH_OFF1 && !led_off |=> phase_q == PH_OFF1)
		else $error("led wait left while led lit");
`endif

endmodule

[rtl/camera_interval_shot_sequencer.sv]
// top level of the camera interval shot sequencer
//
// Each input beat is one 50 ms tick carrying the sampled button and led
// pins; each tick yields exactly one output beat with the power and shutter
// drives and the phase code in force during that tick. One beat is taken
// every clock cycle while the result register is not stalled; a beat passes
// through an input register and the phase update to the result register,
// where its result is held until taken. A stalled result holds the input
// register, which then holds the input. The rate is set by the single
// next-state evaluation of the phase register per tick. Configuration
// writes are taken in any cycle and should be made while no ticks are in flight.
module camera_interval_shot_sequencer
	import cis_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,  // button_level, led_level, zero pad
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [7:0]            m_axis_tdata,  // power_drive, shutter_drive, phase_code[4:0], zero pad
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg;
	res_t res;

	logic       valid_s1, button_s1, led_s1;
	logic       out_valid_q;
	logic [7:0] out_data_q;
	logic       adv;

	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	cis_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cis_phase_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (adv),
		.button  (button_s1),
		.led_off (led_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			button_s1 <= s_axis_tdata[0];
			led_s1    <= s_axis_tdata[1];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			out_data_q <= {1'b0, res.phase_code, res.shutter_drive, res.power_drive};
	end

`ifndef NO_ASSERTIONS
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(button_s1) && $stable(led_s1))
		else $error("stalled tick lost from input register");

	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("processed tick gave no result");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_axis_tready |-> !adv)
		else $error("pending result overwritten");
`endif

endmodule

[dv/testbench.sv]
// self-checking testbench of the camera interval shot sequencer
`timescale 1ns / 1ps

module testbench;
	import cis_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef enum int {
		IDLE_NONE     = 0,
		IDLE_SENDER   = 1,
		IDLE_RECEIVER = 2,
		IDLE_BOTH     = 3
	} idle_mode_t;

	typedef struct {
		logic       button;
		logic       led;
		idle_mode_t mode;
	} tick_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata = '0;  // button_level, led_level, zero pad
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [7:0]            m_axis_tdata;   // power_drive, shutter_drive, phase_code[4:0], zero pad
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	camera_interval_shot_sequencer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #4 clk = ~clk;

	// shadow copy of the sequencer
	cfg_t                        shadow_cfg;
	phase_t                      shadow_phase;
	logic [TICK_COUNT_WIDTH-1:0] delay_left;
	logic [INTERVAL_W-1:0]       interval_left;
	logic [PULSES_W-1:0]         pulses_left;

	tick_t      pending_ticks[$];
	res_t       expected_drives[$];
	tick_t      next_tick;
	idle_mode_t driven_mode = IDLE_NONE;
	res_t       want_drives, got_drives;

	int cycle_count = 0;
	int ticks_accepted = 0;
	int beats_checked = 0;
	int mismatch_count = 0;
	int settings_count = 0;

	logic led_hold = 1'b0;
	int   led_run_left = 0;
	int   segment_left = 0;
	bit   noise_segment = 1'b0;

	bit directed_button [0:18] = '{1, 0, 1, 0, 1, 1, 0, 0, 1, 0, 1, 0, 1, 1, 0, 0, 0, 1, 1};
	bit directed_led    [0:18] = '{0, 1, 1, 0, 0, 1, 0, 1, 1, 0, 1, 0, 1, 0, 0, 0, 1, 0, 1};

	function automatic void load_delay(phase_t nxt, logic [TICK_COUNT_WIDTH-1:0] ticks);
		shadow_phase = nxt;
		delay_left = ticks;
	endfunction

	function automatic bit delay_expired();
		if (delay_left != 0)
			delay_left = delay_left - 1'b1;
		return delay_left == 0;
	endfunction

	function automatic void begin_shot_cycle();
		interval_left = shadow_cfg.interval_ticks;
		load_delay(PH_PWR_PULSE, TICK_COUNT_WIDTH'(shadow_cfg.power_pulse_ticks));
	endfunction

	function automatic res_t step_sequencer(logic button, logic led_off);
		res_t   r;
		phase_t cur;
		cur = shadow_phase;
		r.power_drive = 1'b0;
		r.shutter_drive = 1'b0;
		r.phase_code = cur;
		if (interval_left != 0)
			interval_left = interval_left - 1'b1;
		case (cur)
			PH_IDLE: begin
				if (button)
					load_delay(PH_KEY_SETTLE, TICK_COUNT_WIDTH'(shadow_cfg.settle_ticks));
			end
			PH_KEY_SETTLE: begin
				if (delay_expired()) begin
					pulses_left = shadow_cfg.flash_count;
					load_delay(PH_FLASH_HI, TICK_COUNT_WIDTH'(shadow_cfg.flash_half_ticks));
				end
			end
			PH_FLASH_HI, PH_EXIT_HI: begin
				r.power_drive = 1'b1;
				if (delay_expired())
					load_delay(phase_t'(cur + 5'd1),
						TICK_COUNT_WIDTH'(shadow_cfg.flash_half_ticks));
			end
			PH_FLASH_LO, PH_EXIT_LO: begin
				if (delay_expired()) begin
					if (pulses_left != 0)
						pulses_left = pulses_left - 1'b1;
					if (pulses_left != 0)
						load_delay(phase_t'(cur - 5'd1),
							TICK_COUNT_WIDTH'(shadow_cfg.flash_half_ticks));
					else if (cur == PH_FLASH_LO)
						load_delay(PH_STARTUP, TICK_COUNT_WIDTH'(shadow_cfg.startup_ticks));
					else
						shadow_phase = PH_IDLE;
				end
			end
			PH_STARTUP: begin
				if (delay_expired())
					begin_shot_cycle();
			end
			PH_PWR_PULSE: begin
				r.power_drive = 1'b1;
				if (delay_expired())
					shadow_phase = PH_OFF1;
			end
			PH_OFF1: begin
				if (led_off)
					shadow_phase = PH_ON1;
			end
			PH_ON1: begin
				if (!led_off)
					load_delay(PH_SHUT_SETTLE, TICK_COUNT_WIDTH'(shadow_cfg.settle_ticks));
			end
			PH_SHUT_SETTLE: begin
				if (delay_expired())
					load_delay(PH_SHUT_PULSE,
						TICK_COUNT_WIDTH'(shadow_cfg.shutter_pulse_ticks));
			end
			PH_SHUT_PULSE: begin
				r.shutter_drive = 1'b1;
				if (delay_expired())
					shadow_phase = PH_OFF2;
			end
			PH_OFF2: begin
				if (led_off)
					shadow_phase = PH_ON2;
			end
			PH_ON2: begin
				if (!led_off)
					load_delay(PH_OFF_SETTLE, TICK_COUNT_WIDTH'(shadow_cfg.settle_ticks));
			end
			PH_OFF_SETTLE: begin
				if (delay_expired())
					shadow_phase = PH_PWR_HOLD;
			end
			PH_PWR_HOLD: begin
				r.power_drive = 1'b1;
				if (led_off)
					shadow_phase = PH_INTERVAL;
			end
			PH_INTERVAL: begin
				if (interval_left == 0) begin
					begin_shot_cycle();
				end else if (button) begin
					pulses_left = shadow_cfg.flash_count;
					load_delay(PH_EXIT_HI, TICK_COUNT_WIDTH'(shadow_cfg.flash_half_ticks));
				end
			end
			default: shadow_phase = PH_IDLE;
		endcase
		return r;
	endfunction

	function automatic bit side_idles(idle_mode_t m, bit sender_side);
		if (m == IDLE_BOTH)
			return $urandom_range(99) < 29;
		if (m == (sender_side ? IDLE_SENDER : IDLE_RECEIVER))
			return $urandom_range(99) < 72;
		return 1'b0;
	endfunction

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// tick driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_drives.push_back(step_sequencer(s_axis_tdata[0], s_axis_tdata[1]));
				ticks_accepted++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_ticks.size() != 0 && !side_idles(pending_ticks[0].mode, 1'b1)) begin
					next_tick = pending_ticks.pop_front();
					driven_mode <= next_tick.mode;
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {6'b0, next_tick.led, next_tick.button};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				beats_checked++;
				if (expected_drives.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected output beat %h", m_axis_tdata);
				end else begin
					want_drives = expected_drives.pop_front();
					got_drives.power_drive = m_axis_tdata[0];
					got_drives.shutter_drive = m_axis_tdata[1];
					got_drives.phase_code = m_axis_tdata[6:2];
					if (got_drives.power_drive !== want_drives.power_drive ||
							got_drives.shutter_drive !== want_drives.shutter_drive ||
							got_drives.phase_code !== want_drives.phase_code ||
							m_axis_tdata[7] !== 1'b0) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("beat %0d: expected pwr %b shut %b phase %0d, got %h",
								beats_checked, want_drives.power_drive,
								want_drives.shutter_drive, want_drives.phase_code,
								m_axis_tdata);
					end
				end
			end
			m_axis_tready <= !side_idles(driven_mode, 1'b0);
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_INTERVAL:      shadow_cfg.interval_ticks = val;
			REG_POWER_PULSE:   shadow_cfg.power_pulse_ticks = val[7:0];
			REG_SHUTTER_PULSE: shadow_cfg.shutter_pulse_ticks = val[7:0];
			REG_SETTLE:        shadow_cfg.settle_ticks = val[7:0];
			REG_STARTUP:       shadow_cfg.startup_ticks = val;
			REG_FLASH_HALF:    shadow_cfg.flash_half_ticks = val[7:0];
			REG_FLASH_COUNT:   shadow_cfg.flash_count = val[3:0];
			default: ;
		endcase
	endtask

	task automatic write_set(input logic [11:0] iv, input logic [11:0] pp, input logic [11:0] sp,
			input logic [11:0] st, input logic [11:0] su, input logic [11:0] fh,
			input logic [11:0] fc);
		write_reg(REG_INTERVAL, iv);
		write_reg(REG_POWER_PULSE, pp);
		write_reg(REG_SHUTTER_PULSE, sp);
		write_reg(REG_SETTLE, st);
		write_reg(REG_STARTUP, su);
		write_reg(REG_FLASH_HALF, fh);
		write_reg(REG_FLASH_COUNT, fc);
		settings_count++;
	endtask

	task automatic queue_tick(input logic button, input logic led, input idle_mode_t mode);
		tick_t t;
		t.button = button;
		t.led = led;
		t.mode = mode;
		pending_ticks.push_back(t);
	endtask

	// mostly led toggling in runs with rare presses, some pure noise
	task automatic queue_random(input int count, input int base);
		logic btn, led;
		for (int n = 0; n < count; n++) begin
			if (segment_left == 0) begin
				noise_segment = ($urandom_range(99) < 20);
				segment_left = noise_segment ? $urandom_range(5, 15) : $urandom_range(20, 60);
			end
			segment_left--;
			if (noise_segment) begin
				btn = 1'($urandom_range(1));
				led = 1'($urandom_range(1));
			end else begin
				if (led_run_left == 0) begin
					led_hold = ~led_hold;
					led_run_left = $urandom_range(1, 6);
				end
				led_run_left--;
				btn = ($urandom_range(99) < 6);
				led = led_hold;
			end
			queue_tick(btn, led, idle_mode_t'((base + n / 40) % 4));
		end
	endtask

	task automatic drain();
		while (pending_ticks.size() != 0 || s_axis_tvalid || expected_drives.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		shadow_cfg.interval_ticks = 12'd600;
		shadow_cfg.power_pulse_ticks = 8'd26;
		shadow_cfg.shutter_pulse_ticks = 8'd1;
		shadow_cfg.settle_ticks = 8'd2;
		shadow_cfg.startup_ticks = 12'd60;
		shadow_cfg.flash_half_ticks = 8'd2;
		shadow_cfg.flash_count = 4'd5;
		shadow_phase = PH_IDLE;
		delay_left = '0;
		interval_left = '0;
		pulses_left = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset values, press leaves the block in key settle
		queue_tick(1'b0, 1'b0, IDLE_NONE);
		queue_tick(1'b0, 1'b1, IDLE_NONE);
		queue_tick(1'b1, 1'b1, IDLE_NONE);
		drain();

		// zero values act as one; zero interval restarts despite the button
		write_set(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
		write_reg(REG_UNUSED, 12'hFFF);
		for (int i = 0; i < 19; i++)
			queue_tick(directed_button[i], directed_led[i], IDLE_NONE);
		queue_random(80, 1);
		drain();

		for (int k = 0; k < 3; k++) begin
			write_set(12'($urandom_range(1, 40)), 12'($urandom_range(1, 4)),
				12'($urandom_range(1, 3)), 12'($urandom_range(1, 3)),
				12'($urandom_range(1, 6)), 12'($urandom_range(1, 2)),
				12'($urandom_range(1, 3)));
			queue_random(110, 2 + k);
			drain();
		end

		write_set(12'd600, 12'd26, 12'd1, 12'd2, 12'd60, 12'd2, 12'd5);
		queue_random(100, 1);
		drain();

		write_set(12'd4095, 12'd1, 12'd2, 12'd1, 12'd3, 12'd1, 12'd2);
		queue_random(100, 2);
		drain();

		// every register at its top, high data bits masked off
		write_set(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
		queue_random(120, 3);
		drain();

		repeat (8) @(posedge clk);
		mismatch_count += expected_drives.size();
		$display("%0d ticks driven under %0d register settings plus reset values",
			ticks_accepted, settings_count);
		$display("%0d output beats checked, %0d mismatches", beats_checked, mismatch_count);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
